>>> hw/rtl/lru_set_assoc_cache_tag_lookup_defines.svh
// Assertion macros used by the RTL back end (lsctl_back)
`ifndef LRU_SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH
`define LRU_SET_ASSOC_CACHE_TAG_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LSCTL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LSCTL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LSCTL_ASSERT_IMP(lbl, ante, cons)
`define LSCTL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/lsctl_pkg.sv
package lsctl_pkg;

    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 62;
    localparam int CNT_W   = 32;
    localparam int ACT_W   = 2;
    localparam int SETB_W  = 4;
    localparam int WAYS_W  = 5;
    localparam int BOFF_W  = 6;
    localparam int SHIFT_W = 7;

    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;

    typedef logic [CNT_W-1:0] cnt_t;

    function automatic cnt_t sat_inc(input cnt_t v, input logic en);
        sat_inc = (en && (v != {CNT_W{1'b1}})) ? v + cnt_t'(1) : v;
    endfunction

endpackage

>>> hw/rtl/lsctl_front.sv
module lsctl_front #(
    parameter int MAX_SET_BITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lsctl_pkg::ACT_W-1:0]   action,
    input  logic [lsctl_pkg::ADDR_W-1:0]  address,
    input  logic [lsctl_pkg::SETB_W-1:0]  set_bits,
    input  logic [lsctl_pkg::BOFF_W-1:0]  boff_bits,
    input  logic                          back_busy,
    output logic                          req_valid,
    input  logic                          req_pop,
    output logic [lsctl_pkg::ACT_W-1:0]   req_action,
    output logic [MAX_SET_BITS-1:0]       req_set,
    output logic [lsctl_pkg::TAG_W-1:0]   req_tag
);
    import lsctl_pkg::*;

    logic [ACT_W-1:0]        q_act_reg [2];
    logic [MAX_SET_BITS-1:0] q_set_reg [2];
    logic [TAG_W-1:0]        q_tag_reg [2];
    logic                    wr_ptr_reg, rd_ptr_reg;
    logic [1:0]              count_reg, count_next;
    logic                    push;
    logic [ADDR_W-1:0]       off_shift, tag_shift;
    logic [MAX_SET_BITS-1:0] set_mask, set_idx;
    logic [SHIFT_W-1:0]      tag_sh;

    assign in_stall = (count_reg == 2'd2) || back_busy;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        for (int i = 0; i < MAX_SET_BITS; i++)
        begin
            set_mask[i] = (SETB_W'(i) < set_bits);
        end
    end

    assign tag_sh    = SHIFT_W'(set_bits) + SHIFT_W'(boff_bits);
    assign off_shift = address >> boff_bits;
    assign tag_shift = address >> tag_sh;
    assign set_idx   = off_shift[MAX_SET_BITS-1:0] & set_mask;

    assign count_next = count_reg + {1'b0, push} - {1'b0, req_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (req_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_act_reg[wr_ptr_reg] <= action;
            q_set_reg[wr_ptr_reg] <= set_idx;
            q_tag_reg[wr_ptr_reg] <= tag_shift[TAG_W-1:0];
        end
    end

    assign req_valid  = (count_reg != 2'd0);
    assign req_action = q_act_reg[rd_ptr_reg];
    assign req_set    = q_set_reg[rd_ptr_reg];
    assign req_tag    = q_tag_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/lsctl_back.sv
`include "lru_set_assoc_cache_tag_lookup_defines.svh"

module lsctl_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lsctl_pkg::WAYS_W-1:0]  ways_eff,
    input  logic                          req_valid,
    output logic                          req_pop,
    input  logic [lsctl_pkg::ACT_W-1:0]   req_action,
    input  logic [MAX_SET_BITS-1:0]       req_set,
    input  logic [lsctl_pkg::TAG_W-1:0]   req_tag,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          was_hit,
    output logic                          was_evicted,
    output logic                          modify_second_hit,
    output logic [lsctl_pkg::CNT_W-1:0]   total_hits,
    output logic [lsctl_pkg::CNT_W-1:0]   total_misses,
    output logic [lsctl_pkg::CNT_W-1:0]   total_evictions
);
    import lsctl_pkg::*;

    localparam int SETS = 1 << MAX_SET_BITS;
    localparam int RW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [MAX_WAYS-1:0]             valid_mem [SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_mem   [SETS];
    logic [MAX_WAYS-1:0][RW-1:0]     rank_mem  [SETS];

    logic [MAX_WAYS-1:0]             rd_valid_reg;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag_reg;
    logic [MAX_WAYS-1:0][RW-1:0]     rd_rank_reg;

    logic [1:0]              state_reg, state_next;
    logic [MAX_SET_BITS-1:0] clr_cnt_reg;
    logic [ACT_W-1:0]        cur_act_reg;
    logic [MAX_SET_BITS-1:0] cur_set_reg;
    logic [TAG_W-1:0]        cur_tag_reg;

    logic out_valid_reg, hit_reg, evict_reg, mod_reg;
    cnt_t hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    cnt_t hit_cnt_next, miss_cnt_next, evict_cnt_next;

    logic                            clearing, update, mem_we;
    logic [MAX_SET_BITS-1:0]         wr_addr;
    logic [MAX_WAYS-1:0]             wr_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  wr_tag;
    logic [MAX_WAYS-1:0][RW-1:0]     wr_rank, clr_rank, new_rank;
    logic [MAX_WAYS-1:0]             new_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;

    logic          hit, found_empty, evict, is_mod;
    logic [RW-1:0] hit_way, empty_way, lru_way, acc_way, best, acc_rank;

    assign clearing = (state_reg == ST_CLEAR);
    assign busy     = clearing;
    assign req_pop  = (state_reg == ST_IDLE) && req_valid;
    assign update   = (state_reg == ST_LOOK) && (!out_valid_reg || !out_stall);
    assign is_mod   = (cur_act_reg == ACT_MODIFY);

    always_comb
    begin
        hit         = 1'b0;
        hit_way     = '0;
        found_empty = 1'b0;
        empty_way   = '0;
        lru_way     = '0;
        best        = rd_rank_reg[0];
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (!hit && (WAYS_W'(w) < ways_eff) && rd_valid_reg[w]
                && (rd_tag_reg[w] == cur_tag_reg))
            begin
                hit     = 1'b1;
                hit_way = RW'(w);
            end
            if (!found_empty && (WAYS_W'(w) < ways_eff) && !rd_valid_reg[w])
            begin
                found_empty = 1'b1;
                empty_way   = RW'(w);
            end
            if ((w > 0) && (WAYS_W'(w) < ways_eff) && (rd_rank_reg[w] > best))
            begin
                best    = rd_rank_reg[w];
                lru_way = RW'(w);
            end
        end
        evict   = !hit && !found_empty;
        acc_way = hit ? hit_way : (found_empty ? empty_way : lru_way);
    end

    assign acc_rank = rd_rank_reg[acc_way];

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            clr_rank[i] = RW'(i);
            if (RW'(i) == acc_way)
            begin
                new_rank[i]  = '0;
                new_valid[i] = 1'b1;
                new_tag[i]   = cur_tag_reg;
            end
            else
            begin
                new_rank[i]  = (rd_rank_reg[i] < acc_rank) ? rd_rank_reg[i] + RW'(1)
                                                           : rd_rank_reg[i];
                new_valid[i] = rd_valid_reg[i];
                new_tag[i]   = rd_tag_reg[i];
            end
        end
    end

    assign mem_we   = clearing || update;
    assign wr_addr  = clearing ? clr_cnt_reg : cur_set_reg;
    assign wr_valid = clearing ? '0 : new_valid;
    assign wr_tag   = clearing ? '0 : new_tag;
    assign wr_rank  = clearing ? clr_rank : new_rank;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            valid_mem[wr_addr] <= wr_valid;
            tag_mem[wr_addr]   <= wr_tag;
            rank_mem[wr_addr]  <= wr_rank;
        end
        if (req_pop)
        begin
            rd_valid_reg <= valid_mem[req_set];
            rd_tag_reg   <= tag_mem[req_set];
            rd_rank_reg  <= rank_mem[req_set];
            cur_act_reg  <= req_action;
            cur_set_reg  <= req_set;
            cur_tag_reg  <= req_tag;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {MAX_SET_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (update)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign hit_cnt_next   = sat_inc(sat_inc(hit_cnt_reg, hit), is_mod);
    assign miss_cnt_next  = sat_inc(miss_cnt_reg, !hit);
    assign evict_cnt_next = sat_inc(evict_cnt_reg, evict);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + MAX_SET_BITS'(1);
            end
            if (update)
            begin
                out_valid_reg <= 1'b1;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                evict_cnt_reg <= evict_cnt_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            hit_reg   <= hit;
            evict_reg <= evict;
            mod_reg   <= is_mod;
        end
    end

    assign out_valid         = out_valid_reg;
    assign was_hit           = hit_reg;
    assign was_evicted       = evict_reg;
    assign modify_second_hit = mod_reg;
    assign total_hits        = hit_cnt_reg;
    assign total_misses      = miss_cnt_reg;
    assign total_evictions   = evict_cnt_reg;

    `LSCTL_ASSERT_IMP(a_pop_idle, req_pop, !clearing && !out_valid_reg || !clearing)
    `LSCTL_ASSERT_IMP(a_evict_miss, out_valid_reg, !(hit_reg && evict_reg))
    `LSCTL_ASSERT_NEXT(a_hit_mono, !update, hit_cnt_reg == $past(hit_cnt_reg))
    `LSCTL_ASSERT_NEXT(a_miss_mono, update, miss_cnt_reg >= $past(miss_cnt_reg))

endmodule

>>> hw/rtl/lru_set_assoc_cache_tag_lookup.sv
// Path: a request is queued, popped with a read of its set row, then written back (update).
// The back end holds one request at a time; the front queue takes new ones meanwhile.
// Reset: asynchronous active low; counters clear and config returns to defaults.
// After reset a clearing pass over every set initializes the tag memory;
// no request is accepted during it; config writes are taken throughout.
module lru_set_assoc_cache_tag_lookup #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lsctl_pkg::ACT_W-1:0]   action,
    input  logic [lsctl_pkg::ADDR_W-1:0]  address,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          was_hit,
    output logic                          was_evicted,
    output logic                          modify_second_hit,
    output logic [lsctl_pkg::CNT_W-1:0]   total_hits,
    output logic [lsctl_pkg::CNT_W-1:0]   total_misses,
    output logic [lsctl_pkg::CNT_W-1:0]   total_evictions
);
    import lsctl_pkg::*;

    localparam logic [1:0] REG_SET_BITS  = 2'd0;
    localparam logic [1:0] REG_WAYS      = 2'd1;
    localparam logic [1:0] REG_BOFF_BITS = 2'd2;

    logic [2:0]        set_bits_reg, ways_reg;
    logic [BOFF_W-1:0] boff_reg;
    logic              cfg_wr;
    logic [SETB_W-1:0] set_eff;
    logic [WAYS_W-1:0] ways_eff;
    logic [BOFF_W-1:0] boff_eff;

    logic                    req_valid, req_pop, back_busy;
    logic [ACT_W-1:0]        req_action;
    logic [MAX_SET_BITS-1:0] req_set;
    logic [TAG_W-1:0]        req_tag;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= 3'd4;
            ways_reg     <= 3'd1;
            boff_reg     <= 6'd4;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_SET_BITS:  set_bits_reg <= pwdata[2:0];
                REG_WAYS:      ways_reg     <= pwdata[2:0];
                REG_BOFF_BITS: boff_reg     <= pwdata[BOFF_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SET_BITS:  prdata = {29'd0, set_bits_reg};
            REG_WAYS:      prdata = {29'd0, ways_reg};
            REG_BOFF_BITS: prdata = {26'd0, boff_reg};
            default:       prdata = '0;
        endcase
    end

    assign set_eff  = (set_bits_reg == 3'd0) ? SETB_W'(1)
                    : ((SETB_W'(set_bits_reg) > SETB_W'(MAX_SET_BITS)) ? SETB_W'(MAX_SET_BITS)
                                                                        : SETB_W'(set_bits_reg));
    assign ways_eff = (ways_reg == 3'd0) ? WAYS_W'(1)
                    : ((WAYS_W'(ways_reg) > WAYS_W'(MAX_WAYS)) ? WAYS_W'(MAX_WAYS)
                                                                : WAYS_W'(ways_reg));
    assign boff_eff = (boff_reg == 6'd0) ? 6'd1 : ((boff_reg > 6'd32) ? 6'd32 : boff_reg);

    lsctl_front #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .address    (address),
        .set_bits   (set_eff),
        .boff_bits  (boff_eff),
        .back_busy  (back_busy),
        .req_valid  (req_valid),
        .req_pop    (req_pop),
        .req_action (req_action),
        .req_set    (req_set),
        .req_tag    (req_tag)
    );

    lsctl_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .ways_eff          (ways_eff),
        .req_valid         (req_valid),
        .req_pop           (req_pop),
        .req_action        (req_action),
        .req_set           (req_set),
        .req_tag           (req_tag),
        .busy              (back_busy),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .was_hit           (was_hit),
        .was_evicted       (was_evicted),
        .modify_second_hit (modify_second_hit),
        .total_hits        (total_hits),
        .total_misses      (total_misses),
        .total_evictions   (total_evictions)
    );

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
    import lsctl_pkg::*;

    localparam int NSETS = 64;
    localparam int NWAYS = 4;
    localparam int LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACT_W-1:0] action = '0;
    logic [ADDR_W-1:0] address = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic was_hit, was_evicted, modify_second_hit;
    logic [CNT_W-1:0] total_hits, total_misses, total_evictions;

    localparam logic [3:0] REG_SETB = 4'd0;
    localparam logic [3:0] REG_WAYS = 4'd4;
    localparam logic [3:0] REG_BOFF = 4'd8;

    typedef struct packed {
        logic hit;
        logic evicted;
        logic mod2;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evicts;
    } access_result_t;

    access_result_t pending_results[$];

    logic valid_m [NSETS][NWAYS];
    logic [TAG_W-1:0] tag_m [NSETS][NWAYS];
    logic [1:0] rank_m [NSETS][NWAYS];
    logic [CNT_W-1:0] hits_m, misses_m, evicts_m;
    logic [2:0] setb_m, ways_m;
    logic [5:0] boff_m;

    int errors = 0;
    int cycles = 0;
    int stall_mode = 0;
    bit timed_out = 0;

    lru_set_assoc_cache_tag_lookup uut (.*);

    always #4 clk = ~clk;

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    function automatic void promote(int set, int w);
        logic [1:0] r;
        r = rank_m[set][w];
        for (int i = 0; i < NWAYS; i++)
            if (rank_m[set][i] < r) rank_m[set][i]++;
        rank_m[set][w] = 0;
    endfunction

    function automatic access_result_t predict_access(logic [1:0] act, logic [63:0] addr);
        int s, e, b, sb, set, victim, empty;
        logic [TAG_W-1:0] tg;
        logic [1:0] best;
        access_result_t res;
        s = (setb_m < 1) ? 1 : (setb_m > 6) ? 6 : setb_m;
        e = (ways_m < 1) ? 1 : (ways_m > 4) ? 4 : ways_m;
        b = (boff_m < 1) ? 1 : (boff_m > 32) ? 32 : boff_m;
        sb = s + b;
        tg = (sb >= 64) ? '0 : TAG_W'(addr >> sb);
        set = int'((addr >> b) & ((64'd1 << s) - 1));
        res = '0;
        victim = 0;
        empty = NWAYS;
        best = 0;
        for (int w = 0; w < e; w++)
            if (!res.hit && valid_m[set][w] && tag_m[set][w] == tg)
            begin
                res.hit = 1'b1;
                victim = w;
            end
        if (res.hit)
        begin
            hits_m = bump(hits_m);
            promote(set, victim);
        end
        else
        begin
            misses_m = bump(misses_m);
            for (int w = e - 1; w >= 0; w--)
                if (!valid_m[set][w]) empty = w;
            if (empty < NWAYS) victim = empty;
            else
            begin
                for (int w = 0; w < e; w++)
                    if (w == 0 || rank_m[set][w] > best)
                    begin
                        best = rank_m[set][w];
                        victim = w;
                    end
                res.evicted = 1'b1;
                evicts_m = bump(evicts_m);
            end
            valid_m[set][victim] = 1'b1;
            tag_m[set][victim] = tg;
            promote(set, victim);
        end
        if (act == ACT_MODIFY) hits_m = bump(hits_m);
        res.mod2 = (act == ACT_MODIFY);
        res.hits = hits_m;
        res.misses = misses_m;
        res.evicts = evicts_m;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                access_result_t x;
                x = pending_results.pop_front();
                if (was_hit !== x.hit) report_mismatch("was_hit", was_hit, x.hit);
                if (was_evicted !== x.evicted)
                    report_mismatch("was_evicted", was_evicted, x.evicted);
                if (modify_second_hit !== x.mod2)
                    report_mismatch("modify_second_hit", modify_second_hit, x.mod2);
                if (total_hits !== x.hits) report_mismatch("total_hits", total_hits, x.hits);
                if (total_misses !== x.misses)
                    report_mismatch("total_misses", total_misses, x.misses);
                if (total_evictions !== x.evicts)
                    report_mismatch("total_evictions", total_evictions, x.evicts);
            end
        end
    end

    always @(negedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge clk)
        if (cycles > LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end

    task automatic write_reg(logic [3:0] a, logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (a)
            REG_SETB: setb_m = d[2:0];
            REG_WAYS: ways_m = d[2:0];
            default: boff_m = d[5:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(int s, int w, int b);
        wait_drained();
        write_reg(REG_SETB, s);
        write_reg(REG_WAYS, w);
        write_reg(REG_BOFF, b);
    endtask

    task automatic send_request(logic [1:0] act, logic [63:0] addr);
        @(negedge clk);
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(predict_access(act, addr));
    endtask

    task automatic idle_gap();
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic run_burst_traffic(int n, int span);
        int left;
        left = 0;
        for (int i = 0; i < n; i++)
        begin
            logic [63:0] a;
            if (left == 0)
            begin
                idle_gap();
                left = $urandom_range(1, 12);
            end
            left--;
            if ($urandom_range(0, 9) == 0) a = rand64();
            else a = 64'($urandom_range(0, span)) << $urandom_range(0, 6);
            send_request(2'($urandom_range(0, 3)), a);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_request(ACT_LOAD, 64'h0);
        send_request(ACT_LOAD, 64'h0);
        send_request(ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(2'd3, 64'h8000_0000_0000_0000);
        send_request(ACT_MODIFY, 64'h1234_5678_9ABC_DEF0);
        send_request(ACT_LOAD, 64'h1000);
        send_request(ACT_LOAD, 64'h0);
        @(negedge clk);
        in_valid <= 1'b0;
        configure(6, 4, 32);
        for (int i = 0; i < 6; i++) send_request(ACT_LOAD, 64'(i) << 38);
        send_request(ACT_MODIFY, 64'h0);
        send_request(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
        @(negedge clk);
        in_valid <= 1'b0;
        configure(0, 0, 0);
        send_request(ACT_LOAD, 64'h5);
        send_request(ACT_LOAD, 64'h8);
        @(negedge clk);
        in_valid <= 1'b0;
        configure(7, 7, 63);
        send_request(ACT_STORE, 64'hFFFF_FFFF_0000_0000);
        send_request(ACT_LOAD, 64'hFFFF_FFFF_0000_0000);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 12; p++)
        begin
            stall_mode = p % 3;
            configure($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 63));
            run_burst_traffic(150, 1 << $urandom_range(6, 12));
            if (p == 5) wait_drained();
        end
    endtask

    task automatic test_full_associative_stress();
        stall_mode = 2;
        configure(1, 4, 1);
        run_burst_traffic(50, 32);
    endtask

    initial
    begin
        for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < NWAYS; w++)
            begin
                valid_m[s][w] = 1'b0;
                tag_m[s][w] = '0;
                rank_m[s][w] = 2'(w);
            end
        hits_m = '0; misses_m = '0; evicts_m = '0;
        setb_m = 3'd4; ways_m = 3'd1; boff_m = 6'd4;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_configs();
        test_full_associative_stress();
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lsctl_pkg.sv
hw/rtl/lsctl_front.sv
hw/rtl/lsctl_back.sv
hw/rtl/lru_set_assoc_cache_tag_lookup.sv
test/tb.sv
